### rtl/core/hic_pkg.sv
// Shared types, register map, scan table and event decode for the interrupt controller.
// Used by hic_regs, hic_scan and handheld_interrupt_controller_unit.
`default_nettype none
package hic_pkg;

    localparam int DATA_W   = 8;
    localparam int VEC_W    = 5;
    localparam int PRI_NUM  = 3;
    localparam int GRP_NUM  = 4;
    localparam int SCAN_LEN = 27;
    localparam int S_TDATA_W = 32;
    localparam int M_TDATA_W = 16;
    localparam logic MASTER_EN_RESET = 1'b1;

    // request kinds
    localparam logic [1:0] REQ_EVENT = 2'd0;
    localparam logic [1:0] REQ_READ  = 2'd1;
    localparam logic [1:0] REQ_WRITE = 2'd2;

    // register map
    localparam logic [7:0] ADDR_PRI0 = 8'h20;
    localparam logic [7:0] ADDR_PRI1 = 8'h21;
    localparam logic [7:0] ADDR_PRI2 = 8'h22;
    localparam logic [7:0] ADDR_ENA0 = 8'h23;
    localparam logic [7:0] ADDR_ENA1 = 8'h24;
    localparam logic [7:0] ADDR_ENA2 = 8'h25;
    localparam logic [7:0] ADDR_ENA3 = 8'h26;
    localparam logic [7:0] ADDR_ACT0 = 8'h27;
    localparam logic [7:0] ADDR_ACT1 = 8'h28;
    localparam logic [7:0] ADDR_ACT2 = 8'h29;
    localparam logic [7:0] ADDR_ACT3 = 8'h2A;

    localparam logic [7:0] MASK_PRI2 = 8'h03;
    localparam logic [7:0] MASK_GRP1 = 8'h3F;
    localparam logic [7:0] MASK_GRP3 = 8'hF7;

    typedef struct packed {
        logic       from_cpu;
        logic [7:0] write_data;
        logic [7:0] reg_address;
        logic [7:0] irq_number;
        logic [1:0] req_type;
    } item_t;

    typedef struct packed {
        logic [PRI_NUM-1:0][DATA_W-1:0] pri;
        logic [GRP_NUM-1:0][DATA_W-1:0] ena;
        logic [GRP_NUM-1:0][DATA_W-1:0] act;
        logic                           scan_req;
        logic                           master_en;
    } irq_view_t;

    typedef struct packed {
        logic [1:0] pri_idx;
        logic [7:0] pri_mask;
        logic [1:0] grp;
        logic [7:0] bit_mask;
        logic [4:0] vector;
    } scan_entry_t;

    typedef struct packed {
        logic       hit;
        logic [1:0] grp;
        logic [7:0] bit_mask;
    } evt_t;

    // first matching entry wins
    localparam scan_entry_t SCAN_TABLE [SCAN_LEN] = '{
        '{2'd0, 8'hC0, 2'd0, 8'h80, 5'h03}, '{2'd0, 8'hC0, 2'd0, 8'h40, 5'h04},
        '{2'd0, 8'h30, 2'd0, 8'h20, 5'h05}, '{2'd0, 8'h30, 2'd0, 8'h10, 5'h06},
        '{2'd0, 8'h0C, 2'd0, 8'h08, 5'h07}, '{2'd0, 8'h0C, 2'd0, 8'h04, 5'h08},
        '{2'd0, 8'h03, 2'd0, 8'h02, 5'h09}, '{2'd0, 8'h03, 2'd0, 8'h01, 5'h0A},
        '{2'd1, 8'hC0, 2'd1, 8'h20, 5'h0B}, '{2'd1, 8'hC0, 2'd1, 8'h10, 5'h0C},
        '{2'd1, 8'hC0, 2'd1, 8'h08, 5'h0D}, '{2'd1, 8'hC0, 2'd1, 8'h04, 5'h0E},
        '{2'd2, 8'h03, 2'd3, 8'h80, 5'h0F}, '{2'd2, 8'h03, 2'd3, 8'h40, 5'h10},
        '{2'd1, 8'h30, 2'd1, 8'h02, 5'h13}, '{2'd1, 8'h30, 2'd1, 8'h01, 5'h14},
        '{2'd1, 8'h0C, 2'd2, 8'h80, 5'h15}, '{2'd1, 8'h0C, 2'd2, 8'h40, 5'h16},
        '{2'd1, 8'h0C, 2'd2, 8'h20, 5'h17}, '{2'd1, 8'h0C, 2'd2, 8'h10, 5'h18},
        '{2'd1, 8'h0C, 2'd2, 8'h08, 5'h19}, '{2'd1, 8'h0C, 2'd2, 8'h04, 5'h1A},
        '{2'd1, 8'h0C, 2'd2, 8'h02, 5'h1B}, '{2'd1, 8'h0C, 2'd2, 8'h01, 5'h1C},
        '{2'd1, 8'h03, 2'd3, 8'h04, 5'h1D}, '{2'd1, 8'h03, 2'd3, 8'h02, 5'h1E},
        '{2'd1, 8'h03, 2'd3, 8'h01, 5'h1F}
    };

    // source number to active group and bit
    function automatic evt_t evt_decode(input logic [7:0] num);
        evt_t e;
        e = '{hit: 1'b1, grp: 2'd0, bit_mask: 8'h00};
        case (num)
            8'h03: e = '{1'b1, 2'd0, 8'h80};
            8'h04: e = '{1'b1, 2'd0, 8'h40};
            8'h05: e = '{1'b1, 2'd0, 8'h20};
            8'h06: e = '{1'b1, 2'd0, 8'h10};
            8'h07: e = '{1'b1, 2'd0, 8'h08};
            8'h08: e = '{1'b1, 2'd0, 8'h04};
            8'h09: e = '{1'b1, 2'd0, 8'h02};
            8'h0A: e = '{1'b1, 2'd0, 8'h01};
            8'h0B: e = '{1'b1, 2'd1, 8'h20};
            8'h0C: e = '{1'b1, 2'd1, 8'h10};
            8'h0D: e = '{1'b1, 2'd1, 8'h08};
            8'h0E: e = '{1'b1, 2'd1, 8'h04};
            8'h0F: e = '{1'b1, 2'd3, 8'h80};
            8'h10: e = '{1'b1, 2'd3, 8'h40};
            8'h13: e = '{1'b1, 2'd1, 8'h02};
            8'h14: e = '{1'b1, 2'd1, 8'h01};
            8'h15: e = '{1'b1, 2'd2, 8'h80};
            8'h16: e = '{1'b1, 2'd2, 8'h40};
            8'h17: e = '{1'b1, 2'd2, 8'h20};
            8'h18: e = '{1'b1, 2'd2, 8'h10};
            8'h19: e = '{1'b1, 2'd2, 8'h08};
            8'h1A: e = '{1'b1, 2'd2, 8'h04};
            8'h1B: e = '{1'b1, 2'd2, 8'h02};
            8'h1C: e = '{1'b1, 2'd2, 8'h01};
            default: e = '{1'b0, 2'd0, 8'h00};
        endcase
        return e;
    endfunction

endpackage
`default_nettype wire

### rtl/core/hic_regs.sv
// Priority, enable and active registers with their update and read-back logic.
// Depends on hic_pkg.
`default_nettype none
module hic_regs
    import hic_pkg::*;
(
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic              cfg_we,
    input  wire logic              cfg_wdata,
    input  wire logic              upd,
    input  wire item_t             item,
    output      irq_view_t         view,
    output      logic [DATA_W-1:0] rd_data
);

    logic [PRI_NUM-1:0][DATA_W-1:0] pri_reg, pri_next;
    logic [GRP_NUM-1:0][DATA_W-1:0] ena_reg, ena_next;
    logic [GRP_NUM-1:0][DATA_W-1:0] act_reg, act_next;
    logic                           master_en_reg;
    logic                           scan_req;
    evt_t                           evt;
    logic [DATA_W-1:0]              act_val;

    always_comb begin
        evt      = evt_decode(item.irq_number);
        pri_next = pri_reg;
        ena_next = ena_reg;
        act_next = act_reg;
        scan_req = 1'b0;
        rd_data  = '0;
        act_val  = '0;
        case (item.req_type)
            REQ_EVENT: begin
                if (evt.hit) begin
                    act_next[evt.grp] = act_reg[evt.grp] | evt.bit_mask;
                end
                scan_req = 1'b1;
            end
            REQ_READ: begin
                case (item.reg_address)
                    ADDR_PRI0: rd_data = pri_reg[0];
                    ADDR_PRI1: rd_data = pri_reg[1];
                    ADDR_PRI2: rd_data = pri_reg[2] & MASK_PRI2;
                    ADDR_ENA0: rd_data = ena_reg[0];
                    ADDR_ENA1: rd_data = ena_reg[1] & MASK_GRP1;
                    ADDR_ENA2: rd_data = ena_reg[2];
                    ADDR_ENA3: rd_data = ena_reg[3] & MASK_GRP3;
                    ADDR_ACT0: rd_data = act_reg[0];
                    ADDR_ACT1: rd_data = act_reg[1] & MASK_GRP1;
                    ADDR_ACT2: rd_data = act_reg[2];
                    ADDR_ACT3: rd_data = act_reg[3] & MASK_GRP3;
                    default:   rd_data = '0;
                endcase
            end
            REQ_WRITE: begin
                case (item.reg_address)
                    ADDR_PRI0: pri_next[0] = item.write_data;
                    ADDR_PRI1: pri_next[1] = item.write_data;
                    ADDR_PRI2: pri_next[2] = item.write_data;
                    ADDR_ENA0: ena_next[0] = item.write_data;
                    ADDR_ENA1: ena_next[1] = item.write_data & MASK_GRP1;
                    ADDR_ENA2: ena_next[2] = item.write_data;
                    ADDR_ENA3: ena_next[3] = item.write_data & MASK_GRP3;
                    ADDR_ACT0: act_val = item.write_data;
                    ADDR_ACT1: act_val = item.write_data & MASK_GRP1;
                    ADDR_ACT2: act_val = item.write_data;
                    ADDR_ACT3: act_val = item.write_data & MASK_GRP3;
                    default:   act_val = '0;
                endcase
                // priority and enable writes rescan, active writes do not
                scan_req = (item.reg_address inside {[ADDR_PRI0:ADDR_ENA3]});
                if (item.reg_address inside {[ADDR_ACT0:ADDR_ACT3]}) begin
                    // CPU writes clear the written bits, others load
                    for (int k = 0; k < GRP_NUM; k++) begin
                        if (item.reg_address == ADDR_ACT0 + 8'(k)) begin
                            act_next[k] = item.from_cpu ? (act_reg[k] & ~item.write_data)
                                                        : act_val;
                        end
                    end
                end
            end
            default: begin
                scan_req = 1'b0;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pri_reg       <= '0;
            ena_reg       <= '0;
            act_reg       <= '0;
            master_en_reg <= MASTER_EN_RESET;
        end else begin
            if (upd) begin
                pri_reg <= pri_next;
                ena_reg <= ena_next;
                act_reg <= act_next;
            end
            if (cfg_we) begin
                master_en_reg <= cfg_wdata;
            end
        end
    end

    // the scan looks at the state this word leaves behind
    assign view = '{pri: pri_next, ena: ena_next, act: act_next,
                    scan_req: scan_req, master_en: master_en_reg};

endmodule
`default_nettype wire

### rtl/core/hic_scan.sv
// Fixed-order priority encoder that picks the first enabled and active source.
// Depends on hic_pkg.
`default_nettype none
module hic_scan
    import hic_pkg::*;
(
    input  wire irq_view_t        view,
    output      logic             taken,
    output      logic [VEC_W-1:0] vector
);

    logic [SCAN_LEN-1:0] hit;

    always_comb begin
        for (int i = 0; i < SCAN_LEN; i++) begin
            hit[i] = ((view.pri[SCAN_TABLE[i].pri_idx] & SCAN_TABLE[i].pri_mask) != '0)
                  && ((view.ena[SCAN_TABLE[i].grp] & SCAN_TABLE[i].bit_mask) != '0)
                  && ((view.act[SCAN_TABLE[i].grp] & SCAN_TABLE[i].bit_mask) != '0);
        end
    end

    always_comb begin
        taken  = 1'b0;
        vector = '0;
        // walk from the back so the lowest entry lands last
        for (int i = SCAN_LEN - 1; i >= 0; i--) begin
            if (hit[i]) begin
                taken  = 1'b1;
                vector = SCAN_TABLE[i].vector;
            end
        end
        if (!(view.scan_req && view.master_en)) begin
            taken  = 1'b0;
            vector = '0;
        end
    end

endmodule
`default_nettype wire

### rtl/core/handheld_interrupt_controller_unit.sv
// Top level of the interrupt controller: input word register, register file,
// scan encoder and result register. Depends on hic_pkg, hic_regs, hic_scan.
//
// Usage:
//   s_* channel takes one request word per cycle unless stalled: a source event, a register
//   read or a register write. m_* channel returns exactly one result word per
//   request: read data, plus the dispatched vector when a scan fires.
//   cfg_we/cfg_wdata load the master enable; write it only while idle.
// Path: each accepted word waits in the input register, its result in the result register.
// Throughput: one word per cycle while m_tready is high; the register update,
//   read mux and the 27-entry scan encoder all settle between the input and result registers.
// Reset: synchronous, active low; priority, enable and active registers clear,
//   master enable comes up set, both channels empty.
// Stall: when m_tready is low the result holds, the input register keeps its
//   word, and s_tready drops once the input register is full as well.
`default_nettype none
module handheld_interrupt_controller_unit
    import hic_pkg::*;
(
    input  wire logic                 aclk,
    input  wire logic                 aresetn,
    input  wire logic                 cfg_we,
    input  wire logic                 cfg_wdata,
    input  wire logic                 s_tvalid,
    output      logic                 s_tready,
    // [1:0] req_type, [9:2] irq_number, [17:10] reg_address,
    // [25:18] write_data, [26] from_cpu, [31:27] zero
    input  wire logic [S_TDATA_W-1:0] s_tdata,
    output      logic                 m_tvalid,
    input  wire logic                 m_tready,
    // [7:0] read_data, [8] irq_taken, [13:9] irq_vector, [15:14] zero
    output      logic [M_TDATA_W-1:0] m_tdata
);

    item_t             item_reg;
    logic              in_valid_reg;
    logic              out_valid_reg;
    logic [DATA_W-1:0] rd_data_reg;
    logic              taken_reg;
    logic [VEC_W-1:0]  vector_reg;
    logic              advance;
    irq_view_t         view;
    logic [DATA_W-1:0] rd_data;
    logic              taken;
    logic [VEC_W-1:0]  vector;

    assign advance  = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || advance;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            if (s_tready) begin
                in_valid_reg <= s_tvalid;
            end
            if (advance) begin
                out_valid_reg <= 1'b1;
            end else if (m_tready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tready && s_tvalid) begin
            item_reg <= item_t'(s_tdata[$bits(item_t)-1:0]);
        end
        if (advance) begin
            rd_data_reg <= rd_data;
            taken_reg   <= taken;
            vector_reg  <= vector;
        end
    end

    hic_regs u_regs (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .upd       (advance),
        .item      (item_reg),
        .view      (view),
        .rd_data   (rd_data)
    );

    hic_scan u_scan (
        .view   (view),
        .taken  (taken),
        .vector (vector)
    );

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {{(M_TDATA_W - DATA_W - 1 - VEC_W){1'b0}}, vector_reg, taken_reg,
                       rd_data_reg};

endmodule
`default_nettype wire

### sim/tb_top.sv
`timescale 1ns / 100ps
// Testbench for handheld_interrupt_controller_unit: a directed table of register-map and
// source-event cases, then random bus traffic checked against a behavioral predictor.
// Depends on hic_pkg and the controller RTL.
module tb_top;
    import hic_pkg::*;

    localparam logic [1:0] REQ_NONE    = 2'd3;
    localparam int         STALL_LIMIT = 2000;

    typedef struct packed {
        logic [4:0] irq_vector;
        logic       irq_taken;
        logic [7:0] read_data;
    } irq_result_t;

    localparam irq_result_t NO_RESULT = '0;

    // where a source pends, and which priority field admits it
    typedef struct packed {
        logic       evt_ok;
        logic [1:0] pri_idx;
        logic [7:0] pri_mask;
        logic [1:0] grp;
        logic [7:0] bit_mask;
    } irq_source_t;

    typedef struct {
        logic        set_master;
        logic        master_val;
        item_t       req;
        logic        typed;
        irq_result_t want;
    } dir_row_t;

    logic                 aclk;
    logic                 aresetn   = 1'b0;
    logic                 cfg_we    = 1'b0;
    logic                 cfg_wdata = 1'b0;
    logic                 s_tvalid  = 1'b0;
    logic                 s_tready;
    logic [S_TDATA_W-1:0] s_tdata   = '0;
    logic                 m_tvalid;
    logic                 m_tready  = 1'b0;
    logic [M_TDATA_W-1:0] m_tdata;

    // predicted controller state
    logic [7:0] pri_q [PRI_NUM];
    logic [7:0] ena_q [GRP_NUM];
    logic [7:0] act_q [GRP_NUM];
    logic       master_q;

    irq_result_t pending_results [$];
    dir_row_t    directed_rows [$];
    int send_idle_pct = 37;
    int recv_idle_pct = 57;
    int error_count   = 0;
    int stall_cycles  = 0;
    int n_event       = 0;
    int n_read        = 0;
    int n_write       = 0;
    int n_dispatch    = 0;

    handheld_interrupt_controller_unit dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata)
    );

    initial begin
        aclk = 1'b0;
        forever #4 aclk = ~aclk;
    end

    // vector number doubles as source number; scan order is ascending vector
    function automatic irq_source_t source_map(input logic [4:0] v);
        irq_source_t s;
        s = '0;
        s.evt_ok = (v >= 5'h03 && v <= 5'h10) || (v >= 5'h13 && v <= 5'h1C);
        if (v >= 5'h03 && v <= 5'h0A) begin
            s.grp      = 2'd0;
            s.bit_mask = 8'h80 >> (v - 5'h03);
            s.pri_idx  = 2'd0;
            s.pri_mask = (v <= 5'h04) ? 8'hC0 : (v <= 5'h06) ? 8'h30 :
                         (v <= 5'h08) ? 8'h0C : 8'h03;
        end else if (v >= 5'h0B && v <= 5'h0E) begin
            s.grp      = 2'd1;
            s.bit_mask = 8'h20 >> (v - 5'h0B);
            s.pri_idx  = 2'd1;
            s.pri_mask = 8'hC0;
        end else if (v >= 5'h0F && v <= 5'h10) begin
            s.grp      = 2'd3;
            s.bit_mask = 8'h80 >> (v - 5'h0F);
            s.pri_idx  = 2'd2;
            s.pri_mask = 8'h03;
        end else if (v >= 5'h13 && v <= 5'h14) begin
            s.grp      = 2'd1;
            s.bit_mask = 8'h02 >> (v - 5'h13);
            s.pri_idx  = 2'd1;
            s.pri_mask = 8'h30;
        end else if (v >= 5'h15 && v <= 5'h1C) begin
            s.grp      = 2'd2;
            s.bit_mask = 8'h80 >> (v - 5'h15);
            s.pri_idx  = 2'd1;
            s.pri_mask = 8'h0C;
        end else if (v >= 5'h1D) begin
            s.grp      = 2'd3;
            s.bit_mask = 8'h04 >> (v - 5'h1D);
            s.pri_idx  = 2'd1;
            s.pri_mask = 8'h03;
        end
        return s;
    endfunction

    function automatic logic [7:0] group_mask(input int k);
        return (k == 1) ? MASK_GRP1 : (k == 3) ? MASK_GRP3 : 8'hFF;
    endfunction

    function automatic irq_result_t scan_sources();
        irq_result_t r;
        irq_source_t s;
        int          v;
        r = '0;
        if (master_q) begin
            for (v = 3; v < 32; v++) begin
                s = source_map(v[4:0]);
                if (!r.irq_taken && s.bit_mask != 8'h00 &&
                    (pri_q[s.pri_idx] & s.pri_mask) != 8'h00 &&
                    (ena_q[s.grp] & act_q[s.grp] & s.bit_mask) != 8'h00) begin
                    r.irq_taken  = 1'b1;
                    r.irq_vector = v[4:0];
                end
            end
        end
        return r;
    endfunction

    function automatic logic [7:0] read_register(input logic [7:0] a);
        if (a >= ADDR_PRI0 && a <= ADDR_PRI2)
            return (a == ADDR_PRI2) ? (pri_q[2] & MASK_PRI2) : pri_q[int'(a - ADDR_PRI0)];
        if (a >= ADDR_ENA0 && a <= ADDR_ENA3)
            return ena_q[int'(a - ADDR_ENA0)] & group_mask(int'(a - ADDR_ENA0));
        if (a >= ADDR_ACT0 && a <= ADDR_ACT3)
            return act_q[int'(a - ADDR_ACT0)] & group_mask(int'(a - ADDR_ACT0));
        return 8'h00;
    endfunction

    // advance the predicted state by one request and return its result word
    function automatic irq_result_t apply_request(input item_t it);
        irq_result_t r;
        irq_source_t s;
        int          k;
        r = '0;
        case (it.req_type)
            REQ_EVENT: begin
                if (it.irq_number < 8'd32) begin
                    s = source_map(it.irq_number[4:0]);
                    if (s.evt_ok)
                        act_q[s.grp] |= s.bit_mask;
                end
                r = scan_sources();
            end
            REQ_READ: begin
                r.read_data = read_register(it.reg_address);
            end
            REQ_WRITE: begin
                if (it.reg_address >= ADDR_PRI0 && it.reg_address <= ADDR_PRI2) begin
                    pri_q[int'(it.reg_address - ADDR_PRI0)] = it.write_data;
                    r = scan_sources();
                end else if (it.reg_address >= ADDR_ENA0 && it.reg_address <= ADDR_ENA3) begin
                    k = int'(it.reg_address - ADDR_ENA0);
                    ena_q[k] = it.write_data & group_mask(k);
                    r = scan_sources();
                end else if (it.reg_address >= ADDR_ACT0 && it.reg_address <= ADDR_ACT3) begin
                    // CPU acknowledges by clearing, anyone else loads; no scan either way
                    k = int'(it.reg_address - ADDR_ACT0);
                    if (it.from_cpu)
                        act_q[k] = act_q[k] & ~it.write_data;
                    else
                        act_q[k] = it.write_data & group_mask(k);
                end
            end
            default: begin
            end
        endcase
        return r;
    endfunction

    function automatic item_t random_request();
        item_t       it;
        logic [31:0] raw;
        int          sel;
        raw = $urandom;
        it  = raw[$bits(item_t)-1:0];
        sel = $urandom_range(99);
        if (sel < 36) begin
            it.req_type = REQ_EVENT;
            if ($urandom_range(9) != 0)
                it.irq_number = 8'($urandom_range(8'h1C, 8'h03));
        end else if (sel < 56) begin
            it.req_type = REQ_READ;
            if ($urandom_range(9) != 0)
                it.reg_address = 8'($urandom_range(ADDR_ACT3, ADDR_PRI0));
        end else if (sel < 94) begin
            it.req_type = REQ_WRITE;
            if ($urandom_range(9) != 0)
                it.reg_address = 8'($urandom_range(ADDR_ACT3, ADDR_PRI0));
            // acknowledge a single source now and then, as an ISR would
            if (it.reg_address >= ADDR_ACT0 && it.reg_address <= ADDR_ACT3 &&
                it.from_cpu && $urandom_range(1) == 1)
                it.write_data = 8'h01 << $urandom_range(7);
        end else if (sel < 97) begin
            it.req_type = REQ_NONE;
        end
        return it;
    endfunction

    task automatic add_row(input logic setm, input logic mval, input logic [1:0] kind,
                           input logic [7:0] num, input logic [7:0] addr,
                           input logic [7:0] wdata, input logic cpu,
                           input logic typed, input irq_result_t want);
        dir_row_t row;
        row.set_master = setm;
        row.master_val = mval;
        row.req        = '{from_cpu: cpu, write_data: wdata, reg_address: addr,
                           irq_number: num, req_type: kind};
        row.typed      = typed;
        row.want       = want;
        directed_rows.push_back(row);
    endtask

    task automatic send_request(input item_t it, input logic typed, input irq_result_t want);
        irq_result_t r;
        while ($urandom_range(99) < send_idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {{(S_TDATA_W-$bits(item_t)){1'b0}}, it};
        @(posedge aclk);
        while (!s_tready)
            @(posedge aclk);
        r = apply_request(it);
        if (typed)
            r = want;
        pending_results.push_back(r);
        n_event    += (it.req_type == REQ_EVENT);
        n_read     += (it.req_type == REQ_READ);
        n_write    += (it.req_type == REQ_WRITE);
        n_dispatch += r.irq_taken;
    endtask

    // drain, then load the master enable while nothing is in flight
    task automatic set_master(input logic val);
        s_tvalid <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge aclk);
        @(posedge aclk);
        cfg_we    <= 1'b1;
        cfg_wdata <= val;
        @(posedge aclk);
        cfg_we    <= 1'b0;
        master_q = val;
    endtask

    task automatic run_traffic(input int n_items, input int s_pct, input int r_pct,
                               input logic master);
        set_master(master);
        send_idle_pct = s_pct;
        recv_idle_pct = r_pct;
        repeat (n_items)
            send_request(random_request(), 1'b0, NO_RESULT);
    endtask

    function automatic void compare_field(input string name, input int exp_v, input int act_v);
        if (exp_v != act_v) begin
            error_count++;
            $display("%0t ns: %s mismatch, expected %0h, got %0h", $time, name, exp_v, act_v);
        end
    endfunction

    always @(posedge aclk) begin
        irq_result_t got;
        irq_result_t exp_r;
        if (aresetn && ((s_tvalid && s_tready) || (m_tvalid && m_tready)))
            stall_cycles = 0;
        else
            stall_cycles++;
        if (aresetn && m_tvalid && m_tready) begin
            got = m_tdata[$bits(irq_result_t)-1:0];
            if (pending_results.size() == 0) begin
                error_count++;
                $display("%0t ns: result word %h with nothing expected", $time, got);
            end else begin
                exp_r = pending_results.pop_front();
                compare_field("read_data", exp_r.read_data, got.read_data);
                compare_field("irq_taken", exp_r.irq_taken, got.irq_taken);
                compare_field("irq_vector", exp_r.irq_vector, got.irq_vector);
            end
        end
        m_tready <= ($urandom_range(99) >= recv_idle_pct);
    end

    initial begin
        while (stall_cycles < STALL_LIMIT)
            @(posedge aclk);
        $display("%0t ns: no word moved for %0d cycles", $time, STALL_LIMIT);
        $display("[handheld_interrupt_controller_unit] ERROR");
        $finish;
    end

    initial begin
        master_q = MASTER_EN_RESET;
        foreach (pri_q[i]) pri_q[i] = 8'h00;
        foreach (ena_q[i]) ena_q[i] = 8'h00;
        foreach (act_q[i]) act_q[i] = 8'h00;

        // everything reads zero after reset; unmapped address and unused kind give zero
        add_row(0, 0, REQ_READ,  8'h00, ADDR_PRI0, 8'h00, 0, 1, NO_RESULT);
        add_row(0, 0, REQ_READ,  8'hFF, ADDR_ACT3, 8'hFF, 1, 1, NO_RESULT);
        add_row(0, 0, REQ_READ,  8'h00, 8'hFF,     8'h00, 0, 1, NO_RESULT);
        add_row(0, 0, REQ_NONE,  8'hFF, 8'hFF,     8'hFF, 1, 1, NO_RESULT);
        // source 3 pends, but no priority admits it yet
        add_row(0, 0, REQ_EVENT, 8'h03, 8'h00,     8'h00, 0, 1, NO_RESULT);
        add_row(0, 0, REQ_WRITE, 8'h00, ADDR_PRI0, 8'hFF, 0, 1, NO_RESULT);
        add_row(0, 0, REQ_WRITE, 8'h00, ADDR_ENA0, 8'hFF, 1, 1, {5'h03, 1'b1, 8'h00});
        add_row(0, 0, REQ_WRITE, 8'h00, ADDR_PRI1, 8'hFF, 0, 0, NO_RESULT);
        add_row(0, 0, REQ_WRITE, 8'h00, ADDR_ENA1, 8'hFF, 0, 0, NO_RESULT);
        add_row(0, 0, REQ_READ,  8'h00, ADDR_ENA1, 8'h00, 0, 1, {5'h00, 1'b0, MASK_GRP1});
        add_row(0, 0, REQ_WRITE, 8'h00, ADDR_PRI2, 8'hFF, 0, 0, NO_RESULT);
        add_row(0, 0, REQ_READ,  8'h00, ADDR_PRI2, 8'h00, 0, 1, {5'h00, 1'b0, MASK_PRI2});
        add_row(0, 0, REQ_WRITE, 8'h00, ADDR_ENA2, 8'hFF, 0, 0, NO_RESULT);
        add_row(0, 0, REQ_WRITE, 8'h00, ADDR_ENA3, 8'hFF, 0, 0, NO_RESULT);
        add_row(0, 0, REQ_READ,  8'h00, ADDR_ENA3, 8'h00, 0, 1, {5'h00, 1'b0, MASK_GRP3});
        // load then acknowledge active bits
        add_row(0, 0, REQ_WRITE, 8'h00, ADDR_ACT1, 8'hFF, 0, 1, NO_RESULT);
        add_row(0, 0, REQ_READ,  8'h00, ADDR_ACT1, 8'h00, 0, 1, {5'h00, 1'b0, MASK_GRP1});
        add_row(0, 0, REQ_WRITE, 8'h00, ADDR_ACT1, 8'hFF, 1, 1, NO_RESULT);
        add_row(0, 0, REQ_WRITE, 8'h00, ADDR_ACT0, 8'hFF, 1, 1, NO_RESULT);
        // last listed source, an unlisted one, and both ends of the number range
        add_row(0, 0, REQ_EVENT, 8'h1C, 8'h00,     8'h00, 0, 0, NO_RESULT);
        add_row(0, 0, REQ_EVENT, 8'h11, 8'h00,     8'h00, 0, 0, NO_RESULT);
        add_row(0, 0, REQ_EVENT, 8'h00, 8'h00,     8'h00, 0, 0, NO_RESULT);
        add_row(0, 0, REQ_EVENT, 8'hFF, 8'hFF,     8'hFF, 1, 0, NO_RESULT);
        add_row(0, 0, REQ_WRITE, 8'h00, 8'h1F,     8'hFF, 1, 1, NO_RESULT);
        // dispatch is muted with the master enable off
        add_row(1, 0, REQ_EVENT, 8'h03, 8'h00,     8'h00, 0, 1, NO_RESULT);
        add_row(1, 1, REQ_WRITE, 8'h00, ADDR_ACT3, 8'hFF, 0, 1, NO_RESULT);
        add_row(0, 0, REQ_WRITE, 8'h00, ADDR_ENA3, 8'hFF, 0, 0, NO_RESULT);

        repeat (11) @(posedge aclk);
        aresetn <= 1'b1;

        foreach (directed_rows[i]) begin
            if (directed_rows[i].set_master)
                set_master(directed_rows[i].master_val);
            send_request(directed_rows[i].req, directed_rows[i].typed, directed_rows[i].want);
        end

        run_traffic(320, 37, 57, 1'b1);
        run_traffic(150, 57, 37, 1'b0);
        run_traffic(150, 57, 37, 1'b1);
        run_traffic(310, 0, 0, 1'b1);

        s_tvalid <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge aclk);
        repeat (4) @(posedge aclk);

        $display("Covered %0d events, %0d reads and %0d writes with %0d dispatches,",
                 n_event, n_read, n_write, n_dispatch);
        $display("master enable off and on, under both stall mixes and at full rate.");
        if (error_count == 0)
            $display("[handheld_interrupt_controller_unit] OK");
        else
            $display("[handheld_interrupt_controller_unit] ERROR");
        $finish;
    end

endmodule
